### rtl/core/heap_block_allocator_unit_macros.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef HEAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define HEAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define HBA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/core/hba_pkg.sv
// Types and constants shared by the heap allocator RTL.
package hba_pkg;

  localparam int POOL_MAX_BYTES = 65536;
  localparam int MAX_BLOCKS     = 256;
  localparam int HEADER_BYTES   = 8;
  localparam int MIN_POOL_BYTES = HEADER_BYTES + 4;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_CHECK   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] req_size;
    logic [15:0] data_offset;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] granted_offset;
    logic [16:0] free_bytes;
  } out_t;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/hba_ram.sv
// Generic simple dual-port RAM with registered read.
module hba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/heap_block_allocator_unit.sv
// Heap block allocator: address-ordered block table kept in one RAM.
//
// Input channel in_valid/in_stall/in_data carries one request word:
// allocate, release or check space. Output channel out_valid/out_stall/
// out_data returns exactly one result word per request, in order.
// The block takes one request at a time. A request walks the block table
// through the single RAM read port, one entry per cycle. An allocate that
// splits a block then moves every entry above the split point up by one;
// a release that merges moves every entry above the merged blocks down.
// The result sits in an output register; while the receiver stalls it is
// held, and the next request is still taken and worked on, waiting only
// before its own result is written.
// cfg_we writes the pool size (clamped to 12..65536) and re-initialises
// the pool as one free block; write it only while the block is idle.
// Reset sets the pool to 65536 bytes. After reset or a configuration
// write, the init state writes a single free block to the table and the
// input opens. No clearing pass is needed: entries past the count are unread.
module heap_block_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hba_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hba_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_data
);
  import hba_pkg::*;
  `include "heap_block_allocator_unit_macros.svh"

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHUP, S_WLO, S_WHI,
    S_RNEXT, S_RWAIT, S_MERGE, S_SHDN, S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  ra;
  logic              rv;
  logic [IDX_W-1:0]  pidx;
  logic [CNT_W-1:0]  count;
  logic [SIZE_W-1:0] busy;
  logic [SIZE_W-1:0] pool;
  logic [1:0]        op;
  logic [SIZE_W-1:0] rs;
  logic [OFF_W-1:0]  doff;
  logic              found;
  logic [IDX_W-1:0]  best;
  logic [OFF_W-1:0]  best_off;
  logic [SIZE_W-1:0] max_size;
  entry_t            prev;
  entry_t            cur;
  entry_t            nxt;
  logic [IDX_W-1:0]  cur_idx;
  logic              has_next;
  logic              mp_en;
  logic [1:0]        k;
  logic              res_ok;
  logic [OFF_W-1:0]  res_grant;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              issue;
  logic              hit;
  entry_t            rdata;
  logic [SIZE_W-1:0] rs_calc;
  logic [SIZE_W-1:0] pool_clamp;
  logic              merge_next;
  logic [SIZE_W-1:0] merge_size;
  logic [OFF_W-1:0]  merge_off;
  logic [IDX_W-1:0]  merge_idx;

  hba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (ra[IDX_W-1:0]),
    .rd_data (rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    rs_calc = ({1'b0, in_data.req_size} + SIZE_W'(3)) & ~SIZE_W'(3);
    if (cfg_data < SIZE_W'(MIN_POOL_BYTES)) begin
      pool_clamp = SIZE_W'(MIN_POOL_BYTES);
    end else if (cfg_data > SIZE_W'(POOL_MAX_BYTES)) begin
      pool_clamp = SIZE_W'(POOL_MAX_BYTES);
    end else begin
      pool_clamp = cfg_data;
    end

    hit = 1'b0;
    if (state == S_SCAN && rv) begin
      priority if (op == FUNC_ALLOC) begin
        hit = !rdata.used && rdata.size == rs;
      end else if (op == FUNC_RELEASE) begin
        hit = rdata.used &&
              ({1'b0, rdata.off} + SIZE_W'(HEADER_BYTES)) == {1'b0, doff};
      end else begin
        hit = !rdata.used && rdata.size >= rs;
      end
    end

    unique case (state)
      S_SCAN:  issue = (ra < count) && !hit;
      S_SHUP:  issue = ra > {1'b0, best};
      S_SHDN:  issue = ra < count;
      S_RNEXT: issue = 1'b1;
      default: issue = 1'b0;
    endcase

    merge_next = has_next && !nxt.used;
    merge_size = cur.size;
    if (mp_en) begin
      merge_size = merge_size + prev.size + SIZE_W'(HEADER_BYTES);
    end
    if (merge_next) begin
      merge_size = merge_size + nxt.size + SIZE_W'(HEADER_BYTES);
    end
    merge_off = mp_en ? prev.off : cur.off;
    merge_idx = mp_en ? cur_idx - IDX_W'(1) : cur_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      pool      <= SIZE_W'(POOL_MAX_BYTES);
      wr_en     <= 1'b0;
      rv        <= 1'b0;
      count     <= CNT_W'(1);
      busy      <= SIZE_W'(HEADER_BYTES);
    end else if (cfg_we) begin
      pool  <= pool_clamp;
      wr_en <= 1'b0;
      count <= CNT_W'(1);
      busy  <= SIZE_W'(HEADER_BYTES);
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT: begin
          wr_en        <= 1'b1;
          wr_addr      <= '0;
          wr_data.used <= 1'b0;
          wr_data.size <= pool - SIZE_W'(HEADER_BYTES);
          wr_data.off  <= '0;
          count        <= CNT_W'(1);
          busy         <= SIZE_W'(HEADER_BYTES);
          state        <= S_IDLE;
        end
        S_IDLE: begin
          wr_en <= 1'b0;
          if (in_valid) begin
            op        <= in_data.func;
            rs        <= rs_calc;
            doff      <= in_data.data_offset;
            ra        <= '0;
            rv        <= 1'b0;
            found     <= 1'b0;
            max_size  <= '0;
            res_ok    <= 1'b0;
            res_grant <= '0;
            if (in_data.func == FUNC_RELEASE) begin
              state <= S_SCAN;
            end else if ((in_data.func == FUNC_ALLOC || in_data.func == FUNC_CHECK)
                         && in_data.req_size != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          rv    <= issue;
          pidx  <= ra[IDX_W-1:0];
          wr_en <= (hit && op == FUNC_ALLOC) ||
                   (!hit && !rv && !issue && op == FUNC_ALLOC && found &&
                    max_size - rs < SIZE_W'(HEADER_BYTES));
          if (issue) begin
            ra <= ra + CNT_W'(1);
          end
          // hold the entry below the one under test
          if (rv && !hit) begin
            prev <= rdata;
          end
          if (hit) begin
            res_ok <= 1'b1;
            priority if (op == FUNC_ALLOC) begin
              wr_addr      <= pidx;
              wr_data.used <= 1'b1;
              wr_data.size <= rdata.size;
              wr_data.off  <= rdata.off;
              busy         <= busy + rs;
              res_grant    <= rdata.off + OFF_W'(HEADER_BYTES);
              state        <= S_DONE;
            end else if (op == FUNC_RELEASE) begin
              cur     <= rdata;
              cur_idx <= pidx;
              mp_en   <= (pidx != '0) && !prev.used;
              busy    <= busy - rdata.size;
              if ({1'b0, pidx} + CNT_W'(1) < count) begin
                ra    <= {1'b0, pidx} + CNT_W'(1);
                state <= S_RNEXT;
              end else begin
                has_next <= 1'b0;
                state    <= S_MERGE;
              end
            end else begin
              state <= S_DONE;
            end
          end else if (rv) begin
            if (op == FUNC_ALLOC && !rdata.used && rdata.size > rs
                && rdata.size > max_size) begin
              max_size <= rdata.size;
              best     <= pidx;
              best_off <= rdata.off;
              found    <= 1'b1;
            end
          end else if (!issue) begin
            // table walked without a hit
            if (op == FUNC_ALLOC && found) begin
              if (max_size - rs < SIZE_W'(HEADER_BYTES)) begin
                wr_addr      <= best;
                wr_data.used <= 1'b1;
                wr_data.size <= max_size;
                wr_data.off  <= best_off;
                busy         <= busy + max_size;
                res_ok       <= 1'b1;
                res_grant    <= best_off + OFF_W'(HEADER_BYTES);
                state        <= S_DONE;
              end else if (count == CNT_W'(MAX_BLOCKS)) begin
                state <= S_DONE;
              end else begin
                ra    <= count - CNT_W'(1);
                state <= S_SHUP;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SHUP: begin
          // move entries above the split point up by one
          rv    <= issue;
          pidx  <= ra[IDX_W-1:0];
          wr_en <= rv;
          if (issue) begin
            ra <= ra - CNT_W'(1);
          end
          if (rv) begin
            wr_addr <= pidx + IDX_W'(1);
            wr_data <= rdata;
          end
          if (!issue && !rv) begin
            state <= S_WLO;
          end
        end
        S_WLO: begin
          wr_en        <= 1'b1;
          wr_addr      <= best;
          wr_data.used <= 1'b1;
          wr_data.size <= rs;
          wr_data.off  <= best_off;
          state        <= S_WHI;
        end
        S_WHI: begin
          wr_en        <= 1'b1;
          wr_addr      <= best + IDX_W'(1);
          wr_data.used <= 1'b0;
          wr_data.size <= max_size - rs - SIZE_W'(HEADER_BYTES);
          wr_data.off  <= best_off + OFF_W'(HEADER_BYTES) + rs[OFF_W-1:0];
          count        <= count + CNT_W'(1);
          busy         <= busy + rs + SIZE_W'(HEADER_BYTES);
          res_ok       <= 1'b1;
          res_grant    <= best_off + OFF_W'(HEADER_BYTES);
          state        <= S_DONE;
        end
        S_RNEXT: begin
          wr_en <= 1'b0;
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          wr_en    <= 1'b0;
          nxt      <= rdata;
          has_next <= 1'b1;
          state    <= S_MERGE;
        end
        S_MERGE: begin
          wr_en        <= 1'b1;
          wr_addr      <= merge_idx;
          wr_data.used <= 1'b0;
          wr_data.size <= merge_size;
          wr_data.off  <= merge_off;
          busy <= busy - (SIZE_W'(mp_en) + SIZE_W'(merge_next)) * SIZE_W'(HEADER_BYTES);
          k    <= 2'(mp_en) + 2'(merge_next);
          ra   <= {1'b0, cur_idx} + CNT_W'(1) + CNT_W'(merge_next);
          rv   <= 1'b0;
          if (mp_en || merge_next) begin
            state <= S_SHDN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHDN: begin
          // close the gap left by merged entries
          rv    <= issue;
          pidx  <= ra[IDX_W-1:0];
          wr_en <= rv;
          if (issue) begin
            ra <= ra + CNT_W'(1);
          end
          if (rv) begin
            wr_addr <= pidx - IDX_W'(k);
            wr_data <= rdata;
          end
          if (!issue && !rv) begin
            count <= count - CNT_W'(k);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          wr_en <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_data.ok             <= res_ok;
            out_data.granted_offset <= res_grant;
            out_data.free_bytes     <= (busy <= pool) ? pool - busy : '0;
            state                   <= S_IDLE;
          end
        end
        default: begin
          wr_en <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // load a new result word, or drop the one taken by the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && !cfg_we && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `HBA_ASSERT_ALWAYS(a_count_range, count != '0 && count <= CNT_W'(MAX_BLOCKS), "bad count")
  `HBA_ASSERT_ALWAYS(a_busy_le_pool, busy <= pool, "busy bytes exceed pool")
  `HBA_ASSERT_ALWAYS(a_no_rw_clash, !(wr_en && issue && wr_addr == ra[IDX_W-1:0]), "rw clash")
  `HBA_ASSERT_NEXT(a_accept_moves, in_valid && !in_stall && !cfg_we, state != S_IDLE, "word lost")

endmodule

### test/testbench.sv
// Self-checking testbench for the heap block allocator: directed table, then random traffic.
module testbench;
  import hba_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t result;
  } row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  logic  cfg_we;
  logic  [16:0] cfg_data;

  // Shadow of the block table
  int unsigned blk_off[MAX_BLOCKS];
  int unsigned blk_size[MAX_BLOCKS];
  bit          blk_used[MAX_BLOCKS];
  int unsigned blk_count;
  int unsigned busy_bytes;
  int unsigned pool_size;

  out_t results_due[$];
  row_t directed_rows[$];
  int   errors;
  int   idle_cycles;
  bit   quiet;
  bit   hold_now;

  heap_block_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void pool_reset(int unsigned p);
    if (p < HEADER_BYTES + 4) p = HEADER_BYTES + 4;
    if (p > POOL_MAX_BYTES) p = POOL_MAX_BYTES;
    pool_size = p;
    blk_off[0] = 0;
    blk_size[0] = p - HEADER_BYTES;
    blk_used[0] = 0;
    blk_count = 1;
    busy_bytes = HEADER_BYTES;
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned j = i; j + 1 < blk_count; j++) begin
      blk_off[j] = blk_off[j+1];
      blk_size[j] = blk_size[j+1];
      blk_used[j] = blk_used[j+1];
    end
    blk_count--;
  endfunction

  function automatic bit grab(int unsigned req, output int unsigned grant);
    int unsigned rs, best, biggest;
    bit found;
    best = 0;
    biggest = 0;
    found = 0;
    grant = 0;
    if (req == 0) return 0;
    rs = (req + 3) & ~32'd3;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_used[i]) begin
        if (blk_size[i] == rs) begin
          blk_used[i] = 1;
          busy_bytes += rs;
          grant = blk_off[i] + HEADER_BYTES;
          return 1;
        end
        if (blk_size[i] > rs && blk_size[i] > biggest) begin
          biggest = blk_size[i];
          best = i;
          found = 1;
        end
      end
    end
    if (!found) return 0;
    // leftover too small for a header: hand over the whole block
    if (biggest - rs < HEADER_BYTES) begin
      blk_used[best] = 1;
      busy_bytes += biggest;
      grant = blk_off[best] + HEADER_BYTES;
      return 1;
    end
    if (blk_count >= MAX_BLOCKS) return 0;
    for (int unsigned j = blk_count; j > best + 1; j--) begin
      blk_off[j] = blk_off[j-1];
      blk_size[j] = blk_size[j-1];
      blk_used[j] = blk_used[j-1];
    end
    blk_count++;
    blk_size[best] = rs;
    blk_used[best] = 1;
    blk_off[best+1] = blk_off[best] + HEADER_BYTES + rs;
    blk_size[best+1] = biggest - rs - HEADER_BYTES;
    blk_used[best+1] = 0;
    busy_bytes += rs + HEADER_BYTES;
    grant = blk_off[best] + HEADER_BYTES;
    return 1;
  endfunction

  function automatic bit give_back(int unsigned doff);
    int unsigned i, n;
    for (i = 0; i < blk_count; i++)
      if (blk_used[i] && blk_off[i] + HEADER_BYTES == doff) break;
    if (i >= blk_count) return 0;
    blk_used[i] = 0;
    busy_bytes -= blk_size[i];
    n = i;
    if (i > 0 && !blk_used[i-1]) begin
      n = i - 1;
      blk_size[n] += HEADER_BYTES + blk_size[i];
      busy_bytes -= HEADER_BYTES;
      drop_entry(i);
    end
    if (n + 1 < blk_count && !blk_used[n+1]) begin
      blk_size[n] += HEADER_BYTES + blk_size[n+1];
      busy_bytes -= HEADER_BYTES;
      drop_entry(n + 1);
    end
    return 1;
  endfunction

  function automatic bit room_for(int unsigned req);
    int unsigned rs;
    if (req == 0) return 0;
    rs = (req + 3) & ~32'd3;
    for (int unsigned i = 0; i < blk_count; i++)
      if (!blk_used[i] && blk_size[i] >= rs) return 1;
    return 0;
  endfunction

  function automatic out_t heap_apply(in_t w);
    out_t r;
    int unsigned grant;
    bit ok;
    grant = 0;
    ok = 0;
    case (w.func)
      FUNC_ALLOC:   ok = grab(w.req_size, grant);
      FUNC_RELEASE: ok = give_back(w.data_offset);
      FUNC_CHECK:   ok = room_for(w.req_size);
      default:      ok = 0;
    endcase
    if (!ok) grant = 0;
    r.ok = ok;
    r.granted_offset = grant[15:0];
    r.free_bytes = busy_bytes <= pool_size ? 17'(pool_size - busy_bytes) : 17'd0;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send(in_t w, bit typed, out_t want);
    out_t pred;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pred = heap_apply(w);
    results_due.push_back(typed ? want : pred);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_pool(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[16:0];
    pool_reset(v & 32'h1FFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_size(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, top < 64 ? top : 64);
    if (r < 95) return $urandom_range(1, top);
    return $urandom_range(0, 65535);
  endfunction

  // fill: mostly tiny allocations to push the table to its limit
  task automatic random_words(int count, bit fill);
    in_t w;
    out_t none;
    int unsigned r, k, top;
    none = '0;
    for (int n = 0; n < count; n++) begin
      top = pool_size < 4096 ? pool_size : 4096;
      r = $urandom_range(0, 99);
      w.func = FUNC_ALLOC;
      w.req_size = 16'($urandom);
      w.data_offset = 16'($urandom);
      if (fill) begin
        if (r < 85) w.req_size = 16'($urandom_range(1, 4));
        else if (r < 95) w.func = FUNC_RELEASE;
        else w.func = FUNC_CHECK;
      end else if (r < 55) begin
        w.req_size = 16'(pick_size(top));
      end else if (r < 80) begin
        w.func = FUNC_RELEASE;
      end else if (r < 92) begin
        w.func = FUNC_CHECK;
        w.req_size = 16'(pick_size(top));
      end else begin
        w.func = 2'($urandom_range(0, 3));
      end
      // aim most releases at a live block
      if (w.func == FUNC_RELEASE && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, blk_count - 1);
        for (int unsigned j = 0; j < blk_count; j++)
          if (blk_used[(k + j) % blk_count]) begin
            w.data_offset = 16'(blk_off[(k + j) % blk_count] + HEADER_BYTES);
            break;
          end
      end
      send(w, 1'b0, none);
    end
  endtask

  task automatic add_row(logic [1:0] f, int unsigned req, int unsigned doff, bit typed,
                         bit ok, int unsigned grant, int unsigned freeb);
    row_t row;
    row.word.func = f;
    row.word.req_size = req[15:0];
    row.word.data_offset = doff[15:0];
    row.typed = typed;
    row.result.ok = ok;
    row.result.granted_offset = grant[15:0];
    row.result.free_bytes = freeb[16:0];
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("unexpected result word at %0t", $time);
        errors++;
      end else begin
        if (out_data.ok !== results_due[0].ok)
          report("ok", out_data.ok, results_due[0].ok);
        if (out_data.granted_offset !== results_due[0].granted_offset)
          report("granted_offset", out_data.granted_offset, results_due[0].granted_offset);
        if (out_data.free_bytes !== results_due[0].free_bytes)
          report("free_bytes", out_data.free_bytes, results_due[0].free_bytes);
        void'(results_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver side: short stalls, and one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_now) begin
        hold_now = 0;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    errors = 0;
    quiet = 0;
    hold_now = 0;
    pool_reset(65536);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(FUNC_CHECK,   0,     0,     1, 0, 0, 65528);
    add_row(FUNC_ALLOC,   0,     0,     1, 0, 0, 65528);
    add_row(FUNC_ALLOC,   1,     0,     1, 1, 8, 65516);
    add_row(FUNC_ALLOC,   65535, 0,     1, 0, 0, 65516);
    add_row(FUNC_CHECK,   65535, 0,     1, 0, 0, 65516);
    add_row(FUNC_RELEASE, 0,     8,     1, 1, 0, 65528);
    add_row(FUNC_RELEASE, 0,     8,     1, 0, 0, 65528);
    add_row(FUNC_UNUSED,  65535, 65535, 1, 0, 0, 65528);
    add_row(FUNC_ALLOC,   65528, 0,     1, 1, 8, 0);
    add_row(FUNC_CHECK,   4,     0,     1, 0, 0, 0);
    add_row(FUNC_ALLOC,   4,     0,     1, 0, 0, 0);
    add_row(FUNC_RELEASE, 0,     8,     1, 1, 0, 65528);
    add_row(FUNC_ALLOC,   65524, 0,     1, 1, 8, 0);
    add_row(FUNC_RELEASE, 0,     8,     1, 1, 0, 65528);
    add_row(FUNC_ALLOC,   100,   0,     0, 0, 0, 0);
    add_row(FUNC_ALLOC,   201,   0,     0, 0, 0, 0);
    add_row(FUNC_ALLOC,   302,   0,     0, 0, 0, 0);
    add_row(FUNC_RELEASE, 0,     116,   0, 0, 0, 0);
    add_row(FUNC_RELEASE, 0,     8,     0, 0, 0, 0);
    add_row(FUNC_RELEASE, 0,     65535, 0, 0, 0, 0);
    add_row(FUNC_RELEASE, 0,     0,     0, 0, 0, 0);
    add_row(FUNC_CHECK,   65533, 0,     0, 0, 0, 0);
    add_row(FUNC_ALLOC,   3,     0,     0, 0, 0, 0);
    foreach (directed_rows[i])
      send(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

    hold_now = 1;
    random_words(400, 0);
    set_pool(20);
    random_words(100, 0);
    set_pool(5);
    random_words(80, 0);
    set_pool(131071);
    random_words(200, 0);
    set_pool(300);
    random_words(120, 0);
    set_pool(1000);
    random_words(120, 0);
    set_pool(65536);
    quiet = 1;
    random_words(300, 1);
    drain();

    if (errors == 0 && results_due.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
